// ===== hdl/salc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the set-associative LRU cache model
// Holds the word formats of the request and result channels, the register
// indexes, the access and outcome codes and the controller states.
// ----------------------------------------------------------------------------
package salc_pkg;

	// Default values of the top-level parameters.
	localparam int MAX_SET_BITS_DEF = 8;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int ADDR_WIDTH_DEF   = 64;
	localparam int COUNT_WIDTH_DEF  = 32;

	// Fixed field widths of the channels.
	localparam int ADDRESS_W  = 64;
	localparam int TOTAL_W    = 32;
	localparam int STAMP_W    = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;

	// Largest block offset that the block honors.
	localparam logic [4:0] MAX_BLOCK_BITS = 5'd16;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd2;

	// Register reset values.
	localparam logic [3:0] SET_BITS_RST   = 4'd4;
	localparam logic [3:0] WAYS_RST       = 4'd1;
	localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

	// Access kind that performs two accesses; any other kind performs one.
	localparam logic [1:0] MODE_MODIFY = 2'd2;

	// Outcome codes.
	localparam logic [1:0] OUT_HIT   = 2'd0;
	localparam logic [1:0] OUT_MISS  = 2'd1;
	localparam logic [1:0] OUT_EVICT = 2'd2;

	// Request word.
	typedef struct packed {
		logic [1:0]           mode;
		logic [ADDRESS_W-1:0] address;
	} request_t;

	// Result word.
	typedef struct packed {
		logic [1:0]         outcome;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
		logic [TOTAL_W-1:0] eviction_total;
		logic               last;
	} result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_REREAD
	} state_t;

endpackage

// ===== hdl/set_associative_lru_cache_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_associative_lru_cache_model: cache hit/miss model with LRU replacement
// Splits each access address into tag and set, looks the tag up in one set
// row of a synchronous memory, writes the updated row back and reports the
// outcome with saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
//
// Channel   Ports                              Handshake
// -------   --------------------------------   --------------------------------
// request   request (mode, address)            taken when start & !busy
// result    result (outcome, totals, last)     valid one cycle on result_strobe
// config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// A load or store reads the set row, then compares the tag, chooses the
// victim and writes the row back. A modify does this twice, since the
// second access reads the row again after the first one has written it.
// After reset the block sweeps all 2**MAX_SET_BITS rows of the set memory,
// one row a cycle, with busy high; configuration writes are taken then.
// Results are shown for one cycle and are not held; the receiver cannot stall.
//
module set_associative_lru_cache_model #(
	parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
	parameter int ADDR_WIDTH   = salc_pkg::ADDR_WIDTH_DEF,
	parameter int COUNT_WIDTH  = salc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  salc_pkg::request_t                     request,
	output logic                                   result_strobe,
	output salc_pkg::result_t                      result,
	input  logic                                   cfg_we,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import salc_pkg::*;

	localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int NUM_ROWS  = 1 << MAX_SET_BITS;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [SET_IDX_W-1:0] LAST_ROW = SET_IDX_W'(NUM_ROWS - 1);

	// One set of the cache, stored as one memory row.
	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
		logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp;
	} row_t;

	// Configuration registers.
	logic [3:0] set_bits_q;
	logic [3:0] ways_q;
	logic [4:0] block_bits_q;

	// Controller and item registers.
	state_t                state_q, state_d;
	logic [SET_IDX_W-1:0]  clr_q;
	logic [SET_IDX_W-1:0]  set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic                  pend_q;

	// Access clock and totals.
	logic [STAMP_W-1:0]     clock_q;
	logic [COUNT_WIDTH-1:0] hits_q, misses_q, evicts_q;

	// Result register.
	logic    strobe_q;
	result_t result_q;

	// Set memory and its ports.
	row_t                 mem [NUM_ROWS];
	row_t                 row_rd;
	logic                 rd_en, wr_en;
	logic [SET_IDX_W-1:0] rd_addr, wr_addr;
	row_t                 wr_row;

	// Address split of the incoming word.
	logic [3:0]            sb;
	logic [4:0]            bb;
	logic [ADDR_WIDTH-1:0] addr_a, addr_sh;
	logic [SET_IDX_W:0]    set_mask;
	logic [SET_IDX_W-1:0]  set_in;
	logic [ADDR_WIDTH-1:0] tag_in;

	// Lookup results.
	logic [4:0]          ways_eff;
	logic [MAX_WAYS-1:0] in_use, hit_vec, empty_vec, older_vec, win_vec;
	logic                any_hit, any_empty;
	logic [WAY_W-1:0]    hit_way, empty_way, victim_way, sel_way;
	logic [STAMP_W-1:0]  clock_nxt;
	logic [1:0]          outcome;
	row_t                upd_row;

	// Clamp the configured split and form set index and tag.
	always_comb begin
		sb       = (32'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_q;
		bb       = (block_bits_q > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_q;
		addr_a   = request.address[ADDR_WIDTH-1:0];
		addr_sh  = addr_a >> bb;
		set_mask = ((SET_IDX_W+1)'(1) << sb) - (SET_IDX_W+1)'(1);
		set_in   = addr_sh[SET_IDX_W-1:0] & set_mask[SET_IDX_W-1:0];
		tag_in   = addr_a >> (6'(sb) + 6'(bb));
	end

	// Compare the ways of the set row against the tag.
	always_comb begin
		if (ways_q == 4'd0) begin
			ways_eff = 5'd1;
		end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
			ways_eff = 5'(MAX_WAYS);
		end else begin
			ways_eff = {1'b0, ways_q};
		end
		clock_nxt = clock_q + STAMP_W'(1);
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i]    = (i < int'(ways_eff));
			hit_vec[i]   = in_use[i] && row_rd.valid[i] && (row_rd.tag[i] == tag_q);
			empty_vec[i] = in_use[i] && !row_rd.valid[i];
			older_vec[i] = in_use[i] && (row_rd.stamp[i] < clock_nxt);
		end
		// A way wins the LRU choice if no older candidate beats it; the lower
		// index wins a tie.
		for (int i = 0; i < MAX_WAYS; i++) begin
			win_vec[i] = older_vec[i];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (j < i && older_vec[j] && row_rd.stamp[j] <= row_rd.stamp[i]) begin
					win_vec[i] = 1'b0;
				end
				if (j > i && older_vec[j] && row_rd.stamp[j] < row_rd.stamp[i]) begin
					win_vec[i] = 1'b0;
				end
			end
		end
		any_hit    = |hit_vec;
		any_empty  = |empty_vec;
		hit_way    = '0;
		empty_way  = '0;
		victim_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = WAY_W'(i);
			end
			if (empty_vec[i]) begin
				empty_way = WAY_W'(i);
			end
			if (win_vec[i]) begin
				victim_way = WAY_W'(i);
			end
		end
		if (any_hit) begin
			outcome = OUT_HIT;
			sel_way = hit_way;
		end else if (any_empty) begin
			outcome = OUT_MISS;
			sel_way = empty_way;
		end else begin
			outcome = OUT_EVICT;
			sel_way = victim_way;
		end
		// The chosen way becomes valid, holds the tag and takes the new stamp.
		upd_row                 = row_rd;
		upd_row.valid[sel_way]  = 1'b1;
		upd_row.tag[sel_way]    = tag_q;
		upd_row.stamp[sel_way]  = clock_nxt;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = set_in;
		wr_en   = 1'b0;
		wr_addr = set_q;
		wr_row  = upd_row;
		busy    = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				wr_en        = 1'b1;
				wr_addr      = clr_q;
				wr_row       = row_rd;
				wr_row.valid = '0;
				if (clr_q == LAST_ROW) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy  = 1'b0;
				rd_en = start;
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				wr_en   = 1'b1;
				state_d = pend_q ? ST_REREAD : ST_IDLE;
			end
			ST_REREAD: begin
				rd_en   = 1'b1;
				rd_addr = set_q;
				state_d = ST_LOOK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Set memory: one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_rd <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= SET_BITS_RST;
			ways_q       <= WAYS_RST;
			block_bits_q <= BLOCK_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				REG_WAYS:       ways_q       <= cfg_data[3:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Clear sweep counter, pending second access, clock and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			pend_q   <= 1'b0;
			clock_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_IDX_W'(1);
			end
			if (state_q == ST_IDLE && start) begin
				pend_q <= (request.mode == MODE_MODIFY);
			end
			if (state_q == ST_LOOK) begin
				pend_q   <= 1'b0;
				strobe_q <= 1'b1;
				clock_q  <= clock_nxt;
				if (outcome == OUT_HIT) begin
					hits_q <= (&hits_q) ? hits_q : hits_q + COUNT_WIDTH'(1);
				end else begin
					misses_q <= (&misses_q) ? misses_q : misses_q + COUNT_WIDTH'(1);
				end
				if (outcome == OUT_EVICT) begin
					evicts_q <= (&evicts_q) ? evicts_q : evicts_q + COUNT_WIDTH'(1);
				end
			end
		end
	end

	// Item payload and result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			set_q <= set_in;
			tag_q <= tag_in;
		end
		if (state_q == ST_LOOK) begin
			result_q.outcome <= outcome;
			result_q.last    <= !pend_q;
			result_q.hit_total <= (outcome == OUT_HIT) ?
				TOTAL_W'((&hits_q) ? hits_q : hits_q + COUNT_WIDTH'(1)) :
				TOTAL_W'(hits_q);
			result_q.miss_total <= (outcome != OUT_HIT) ?
				TOTAL_W'((&misses_q) ? misses_q : misses_q + COUNT_WIDTH'(1)) :
				TOTAL_W'(misses_q);
			result_q.eviction_total <= (outcome == OUT_EVICT) ?
				TOTAL_W'((&evicts_q) ? evicts_q : evicts_q + COUNT_WIDTH'(1)) :
				TOTAL_W'(evicts_q);
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule
